// File: sv/linear_probe_hash_table_with_aging_unit_defines.svh
// Assertion macros for the hash table unit
`ifndef LINEAR_PROBE_HASH_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// same-cycle implication, reset disabled
`define LPH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disabled
`define LPH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lpht_pkg.sv
// Shared types, codes and tables of the hash table unit
package lpht_pkg;

    localparam int KEY_W   = 64;
    localparam int PLY_W   = 16;
    localparam int IDX_W   = 12;
    localparam int LOG_W   = 4;
    localparam int LIMIT_W = 15;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_PURGE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             side;
        logic [PLY_W-1:0] ply;
    } slot_t;

    typedef struct packed {
        logic ready;
        logic cap;
        logic rd;
        logic probe_step;
        logic sweep_step;
        logic wr_ins;
        logic wr_free;
        logic wr_zero;
        logic purge_end;
        logic clr_end;
        logic set_pend;
        logic pend_hit;
        logic res_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] new_op;
        logic [1:0] op;
        logic       slot_valid;
        logic       match;
        logic       purge_hit;
        logic       probe_last;
        logic       sweep_last;
        logic       out_busy;
    } ctl_stat_t;

    // floor(2^lg * 9 / 10)
    function automatic logic [LIMIT_W-1:0] occ_limit(input logic [LOG_W-1:0] lg);
        logic [LIMIT_W-1:0] r;
        unique case (lg)
            4'd0:  r = 15'd0;
            4'd1:  r = 15'd1;
            4'd2:  r = 15'd3;
            4'd3:  r = 15'd7;
            4'd4:  r = 15'd14;
            4'd5:  r = 15'd28;
            4'd6:  r = 15'd57;
            4'd7:  r = 15'd115;
            4'd8:  r = 15'd230;
            4'd9:  r = 15'd460;
            4'd10: r = 15'd921;
            4'd11: r = 15'd1843;
            4'd12: r = 15'd3686;
            4'd13: r = 15'd7372;
            4'd14: r = 15'd14745;
            default: r = 15'd29491;
        endcase
        return r;
    endfunction

endpackage

// File: sv/lpht_req_if.sv
// Request channel interface
interface lpht_req_if;
    import lpht_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic             side;
    logic [PLY_W-1:0] entry_ply;
    logic [PLY_W-1:0] purge_ply;
    modport source (output valid, cmd, key, side, entry_ply, purge_ply, input ready);
    modport sink (input valid, cmd, key, side, entry_ply, purge_ply, output ready);
endinterface

// File: sv/lpht_rsp_if.sv
// Response channel interface
interface lpht_rsp_if;
    import lpht_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [IDX_W-1:0] slot_index;
    logic             space_ok;
    modport source (output valid, hit, slot_index, space_ok, input ready);
    modport sink (input valid, hit, slot_index, space_ok, output ready);
endinterface

// File: sv/lpht_ctrl.sv
// Controller state machine of the hash table unit
module lpht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  lpht_pkg::ctl_stat_t stat,
    output lpht_pkg::ctl_cmd_t  cmd
);
    import lpht_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SRD  = 3'd4;
    localparam logic [2:0] S_SCHK = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.wr_zero = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
                else
                    cmd.sweep_step = 1'b1;
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (stat.req_valid)
                begin
                    cmd.cap = 1'b1;
                    unique case (stat.new_op)
                        OP_INSERT, OP_FIND: state_next = S_RD;
                        OP_PURGE:           state_next = S_SRD;
                        default:            state_next = S_CLR;
                    endcase
                end
            end
            S_RD:
            begin
                cmd.rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (!stat.slot_valid)
                begin
                    cmd.wr_ins   = (stat.op == OP_INSERT);
                    cmd.set_pend = 1'b1;
                    cmd.pend_hit = (stat.op == OP_INSERT);
                    state_next   = S_DONE;
                end
                else if (stat.op == OP_FIND && stat.match)
                begin
                    cmd.set_pend = 1'b1;
                    cmd.pend_hit = 1'b1;
                    state_next   = S_DONE;
                end
                else if (stat.probe_last)
                begin
                    cmd.set_pend = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_SRD:
            begin
                cmd.rd = 1'b1;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                cmd.wr_free = stat.purge_hit;
                if (stat.sweep_last)
                begin
                    cmd.purge_end = 1'b1;
                    cmd.set_pend  = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                    state_next     = S_SRD;
                end
            end
            S_CLR:
            begin
                cmd.wr_zero = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.clr_end  = 1'b1;
                    cmd.set_pend = 1'b1;
                    state_next   = S_DONE;
                end
                else
                    cmd.sweep_step = 1'b1;
            end
            default:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

endmodule

// File: sv/lpht_dp.sv
// Datapath of the hash table unit: slot memory, probe address, counters, result
`include "linear_probe_hash_table_with_aging_unit_defines.svh"
module lpht_dp #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [lpht_pkg::LOG_W-1:0] cfg_wdata,
    input  lpht_pkg::ctl_cmd_t       cmd,
    output lpht_pkg::ctl_stat_t      stat,
    lpht_req_if.sink                 req,
    lpht_rsp_if.source               rsp
);
    import lpht_pkg::*;

    localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW      = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_LOG = $clog2(TABLE_DEPTH + 1) - 1;

    slot_t mem [TABLE_DEPTH];
    slot_t rdata_reg;

    logic [LOG_W-1:0] size_log2_reg;
    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic             side_reg;
    logic [PLY_W-1:0] eply_reg;
    logic [PLY_W-1:0] pply_reg;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    n_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [PLY_W-1:0] oldest_reg;
    logic             space_reg;
    logic             pend_hit_reg;
    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_space_reg;

    logic [LOG_W-1:0] lg_eff;
    logic [AW-1:0]    mask;
    logic [AW-1:0]    home;
    logic             we;
    slot_t            wdata;

    always_comb
    begin
        lg_eff = size_log2_reg;
        if (size_log2_reg == '0)
            lg_eff = LOG_W'(1);
        else if (int'(size_log2_reg) > MAX_LOG)
            lg_eff = LOG_W'(MAX_LOG);
    end

    assign mask = AW'((64'd1 << lg_eff) - 64'd1);
    assign home = AW'(req.key[31:0] ^ req.key[63:32]) & mask;

    assign we = cmd.wr_ins | cmd.wr_free | cmd.wr_zero;
    always_comb
    begin
        wdata = '0;
        if (cmd.wr_ins)
        begin
            wdata.valid = 1'b1;
            wdata.key   = key_reg;
            wdata.side  = side_reg;
            wdata.ply   = eply_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr_reg] <= wdata;
        if (cmd.rd)
            rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg   <= req.cmd;
            key_reg  <= req.key;
            side_reg <= req.side;
            eply_reg <= req.entry_ply;
            pply_reg <= req.purge_ply;
        end
        if (cmd.set_pend)
            pend_hit_reg <= cmd.pend_hit;
        if (cmd.res_load)
        begin
            out_hit_reg   <= pend_hit_reg;
            out_idx_reg   <= pend_hit_reg ? IDX_W'(addr_reg) : '0;
            out_space_reg <= space_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.clr_end)
            count_next = '0;
        else if (cmd.wr_ins)
            count_next = count_reg + CW'(1);
        else if (cmd.wr_free && count_reg != '0)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= LOG_W'(12);
            addr_reg      <= '0;
            n_reg         <= '0;
            count_reg     <= '0;
            oldest_reg    <= PLY_W'(1);
            space_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                size_log2_reg <= cfg_wdata;
            if (cmd.cap)
            begin
                addr_reg <= (req.cmd == OP_INSERT || req.cmd == OP_FIND) ? home : '0;
                n_reg    <= '0;
            end
            else if (cmd.probe_step)
            begin
                addr_reg <= (addr_reg + AW'(1)) & mask;
                n_reg    <= n_reg + AW'(1);
            end
            else if (cmd.sweep_step)
                addr_reg <= addr_reg + AW'(1);
            count_reg <= count_next;
            if (cmd.wr_ins && 32'(count_next) > 32'(occ_limit(lg_eff)))
                space_reg <= 1'b0;
            if (cmd.purge_end || cmd.clr_end)
                space_reg <= 1'b1;
            if (cmd.purge_end && pply_reg > oldest_reg)
                oldest_reg <= pply_reg;
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign req.ready      = cmd.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.slot_index = out_idx_reg;
    assign rsp.space_ok   = out_space_reg;

    assign stat.req_valid  = req.valid;
    assign stat.new_op     = req.cmd;
    assign stat.op         = op_reg;
    assign stat.slot_valid = rdata_reg.valid;
    assign stat.match      = rdata_reg.key == key_reg && rdata_reg.side == side_reg;
    assign stat.purge_hit  = rdata_reg.valid && rdata_reg.ply >= oldest_reg
                             && rdata_reg.ply < pply_reg;
    assign stat.probe_last = (n_reg == mask);
    assign stat.sweep_last = (addr_reg == AW'(TABLE_DEPTH - 1));
    assign stat.out_busy   = out_valid_reg && !rsp.ready;

    `LPH_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_reg) <= TABLE_DEPTH, "count over depth")
    `LPH_ASSERT_IMP(a_ins_free, cmd.wr_ins, !rdata_reg.valid, "insert over valid slot")
    `LPH_ASSERT_IMP(a_one_write, 1'b1, $onehot0({cmd.wr_ins, cmd.wr_free, cmd.wr_zero}),
        "conflicting writes")
    `LPH_ASSERT_NXT(a_space_fall, !space_reg, !space_reg || $past(cmd.purge_end || cmd.clr_end),
        "space flag set without purge or clear")

endmodule

// File: sv/linear_probe_hash_table_with_aging_unit.sv
// Top level of the linear-probing hash table with ply aging
//   channel | dir | handshake        | word
//   req     | in  | valid/ready      | cmd, key, side, entry_ply, purge_ply
//   rsp     | out | valid/ready      | hit, slot_index, space_ok
//   cfg     | in  | cfg_we           | cfg_wdata = size_log2
// Insert/find: each probed slot is read, then checked; one slot memory read port sets this.
// Purge: every slot is read, then checked and written back if freed. Clear: every slot is zeroed.
// After reset a clearing pass over all TABLE_DEPTH slots runs before req.ready rises.
// One word in flight; a new word is taken while the previous result waits on rsp.
module linear_probe_hash_table_with_aging_unit #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpht_pkg::LOG_W-1:0] cfg_wdata,
    lpht_req_if.sink                   req,
    lpht_rsp_if.source                 rsp
);
    import lpht_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    lpht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    lpht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp)
    );

endmodule

// File: verif/lpht_checker.sv
// Checker for the hash table unit: tracks the table, predicts each result word and compares
module lpht_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpht_pkg::LOG_W-1:0] cfg_wdata,
    lpht_req_if                        req,
    lpht_rsp_if                        rsp,
    output int                         fail_count,
    output int                         outstanding
);
    import lpht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = 4096;
    localparam int MAX_LOG = 12;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic             space;
    } answer_t;

    answer_t          answer_q[$];
    logic             slot_used[DEPTH];
    logic [KEY_W-1:0] slot_key[DEPTH];
    logic             slot_side[DEPTH];
    logic [PLY_W-1:0] slot_ply[DEPTH];
    int unsigned      used_count;
    logic [PLY_W-1:0] oldest_ply;
    logic             space_flag;
    logic [LOG_W-1:0] size_log2;

    function automatic void free_entry(int unsigned i);
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_side[i] = 1'b0;
        slot_ply[i]  = '0;
    endfunction

    function automatic answer_t apply_word(logic [1:0] op, logic [KEY_W-1:0] k, logic s,
                                           logic [PLY_W-1:0] ep, logic [PLY_W-1:0] pp);
        int unsigned lg;
        int unsigned size;
        int unsigned mask;
        int unsigned i;
        int unsigned n;
        answer_t     a;
        lg = 32'(size_log2);
        if (lg < 1)
            lg = 1;
        if (lg > MAX_LOG)
            lg = MAX_LOG;
        size = 1 << lg;
        mask = size - 1;
        a = '0;
        i = (k[31:0] ^ k[63:32]) & mask;
        case (op)
            OP_INSERT:
            begin
                for (n = 0; n < size; n++)
                begin
                    if (!slot_used[i])
                    begin
                        slot_used[i] = 1'b1;
                        slot_key[i]  = k;
                        slot_side[i] = s;
                        slot_ply[i]  = ep;
                        used_count++;
                        if (used_count > (size * 9) / 10)
                            space_flag = 1'b0;
                        a.hit = 1'b1;
                        a.idx = i[IDX_W-1:0];
                        break;
                    end
                    i = (i + 1) & mask;
                end
            end
            OP_FIND:
            begin
                for (n = 0; n < size; n++)
                begin
                    if (!slot_used[i])
                        break;
                    if (slot_key[i] == k && slot_side[i] == s)
                    begin
                        a.hit = 1'b1;
                        a.idx = i[IDX_W-1:0];
                        break;
                    end
                    i = (i + 1) & mask;
                end
            end
            OP_PURGE:
            begin
                for (i = 0; i < DEPTH; i++)
                begin
                    if (slot_used[i] && slot_ply[i] >= oldest_ply && slot_ply[i] < pp)
                    begin
                        free_entry(i);
                        if (used_count > 0)
                            used_count--;
                    end
                end
                if (pp > oldest_ply)
                    oldest_ply = pp;
                space_flag = 1'b1;
            end
            default:
            begin
                for (i = 0; i < DEPTH; i++)
                    free_entry(i);
                used_count = 0;
                space_flag = 1'b1;
            end
        endcase
        a.space = space_flag;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                free_entry(i);
            used_count  = 0;
            oldest_ply  = PLY_W'(1);
            space_flag  = 1'b1;
            size_log2   = 4'd12;
            answer_q    = {};
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                size_log2 = cfg_wdata;
            if (req.valid && req.ready)
                answer_q.push_back(apply_word(req.cmd, req.key, req.side,
                                              req.entry_ply, req.purge_ply));
            if (rsp.valid && rsp.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected word: hit %0d slot %0d space_ok %0d", $time,
                             rsp.hit, rsp.slot_index, rsp.space_ok);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        fail_count++;
                        $display("%0t hit expected %0d actual %0d", $time, want.hit, rsp.hit);
                    end
                    if (rsp.slot_index !== want.idx)
                    begin
                        fail_count++;
                        $display("%0t slot_index expected %0d actual %0d", $time, want.idx,
                                 rsp.slot_index);
                    end
                    if (rsp.space_ok !== want.space)
                    begin
                        fail_count++;
                        $display("%0t space_ok expected %0d actual %0d", $time, want.space,
                                 rsp.space_ok);
                    end
                end
            end
            outstanding = answer_q.size();
        end
    end
endmodule

// File: verif/tb_linear_probe_hash_table_with_aging_unit.sv
// Testbench top: stimulus, handshake pacing, configuration phases and verdict
module tb_linear_probe_hash_table_with_aging_unit;
    import lpht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int POOL_N      = 64;
    localparam int PHASES      = 18;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LOG_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;
    int               cycles;
    bit               no_idle;
    bit               long_hold;

    logic [KEY_W-1:0] key_pool[POOL_N];
    logic             side_pool[POOL_N];
    int               pool_fill;
    logic [PLY_W-1:0] cur_ply;

    lpht_req_if req ();
    lpht_rsp_if rsp ();

    linear_probe_hash_table_with_aging_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    lpht_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side pacing
    initial
    begin
        int w;
        rsp.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold)
                w = 400;
            else
                w = no_idle ? 0 : $urandom_range(0, 9);
            if (w > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (w) @(posedge clk);
                long_hold = 1'b0;
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    task automatic send(logic [1:0] op, logic [KEY_W-1:0] k, logic s,
                        logic [PLY_W-1:0] ep, logic [PLY_W-1:0] pp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.cmd       <= op;
        req.key       <= k;
        req.side      <= s;
        req.entry_ply <= ep;
        req.purge_ply <= pp;
        do
            @(posedge clk);
        while (!req.ready);
        if (op == OP_INSERT)
        begin
            key_pool[pool_fill % POOL_N]  = k;
            side_pool[pool_fill % POOL_N] = s;
            pool_fill++;
        end
    endtask

    task automatic set_size(logic [LOG_W-1:0] v);
        req.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic rand_word();
        int               r;
        int               p;
        logic [KEY_W-1:0] k;
        logic             s;
        logic [PLY_W-1:0] ep;
        r = $urandom_range(0, 99);
        s = 1'($urandom_range(0, 1));
        p = (pool_fill > 0) ? $urandom_range(0, (pool_fill < POOL_N ? pool_fill : POOL_N) - 1)
                            : 0;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 5)
            k[31:0] = k[63:32] ^ $urandom_range(0, 15);
        ep = cur_ply - PLY_W'($urandom_range(0, 12));
        if ($urandom_range(0, 19) == 0)
            ep = PLY_W'($urandom);
        if ($urandom_range(0, 5) == 0)
            cur_ply = cur_ply + PLY_W'(1);
        if (r < 45)
        begin
            if (pool_fill > 0 && $urandom_range(0, 4) == 0)
                k = key_pool[p];
            send(OP_INSERT, k, s, ep, PLY_W'($urandom));
        end
        else if (r < 95)
        begin
            if (pool_fill > 0 && $urandom_range(0, 9) < 7)
            begin
                k = key_pool[p];
                if ($urandom_range(0, 4) != 0)
                    s = side_pool[p];
            end
            send(OP_FIND, k, s, PLY_W'($urandom), PLY_W'($urandom));
        end
        else if (r < 98)
            send(OP_PURGE, k, s, ep,
                 ($urandom_range(0, 7) == 0) ? PLY_W'($urandom) : cur_ply);
        else
            send(OP_CLEAR, k, s, ep, PLY_W'($urandom));
    endtask

    initial
    begin
        logic [LOG_W-1:0] sizes[6];
        int n;
        sizes         = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req.valid     = 1'b0;
        req.cmd       = OP_INSERT;
        req.key       = '0;
        req.side      = 1'b0;
        req.entry_ply = '0;
        req.purge_ply = '0;
        cycles        = 0;
        no_idle       = 1'b0;
        long_hold     = 1'b0;
        pool_fill     = 0;
        cur_ply       = 16'd5;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default size, field extremes
        send(OP_INSERT, '0, 1'b1, 16'hffff, 16'h0000);
        send(OP_INSERT, '1, 1'b0, 16'h0000, 16'hffff);
        send(OP_FIND, '0, 1'b1, 16'h0000, 16'h0000);
        send(OP_FIND, '0, 1'b0, 16'hffff, 16'hffff);
        send(OP_FIND, '1, 1'b0, 16'h0000, 16'h0000);
        send(OP_FIND, 64'h0123_4567_89ab_cdef, 1'b0, 16'h0, 16'h0);
        send(OP_PURGE, '0, 1'b0, 16'h0, 16'hffff);
        send(OP_FIND, '1, 1'b0, 16'h0, 16'h0);
        // size below range is taken as two slots
        set_size(4'd0);
        send(OP_INSERT, 64'h5, 1'b0, 16'd3, 16'd0);
        send(OP_INSERT, 64'h5, 1'b0, 16'd3, 16'd0);
        send(OP_INSERT, 64'h7, 1'b1, 16'd3, 16'd0);
        send(OP_FIND, 64'h9, 1'b1, 16'd0, 16'd0);
        send(OP_FIND, 64'h5, 1'b0, 16'd0, 16'd0);
        send(OP_PURGE, '0, 1'b0, 16'd0, 16'd2);
        send(OP_CLEAR, '0, 1'b0, 16'd0, 16'd0);
        send(OP_INSERT, 64'hffff_ffff_0000_0001, 1'b1, 16'd9, 16'd0);
        // size above range is taken as the full depth; old entries stay counted
        set_size(4'd15);
        send(OP_FIND, 64'hffff_ffff_0000_0001, 1'b1, 16'd0, 16'd0);
        send(OP_INSERT, 64'h0000_0001_0000_0fff, 1'b0, 16'd9, 16'd0);
        send(OP_CLEAR, '0, 1'b0, 16'd0, 16'd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 4)
                set_size(4'd12);
            else if (ph == 9)
                set_size(4'd1);
            else if (ph == 13)
                set_size(4'd13);
            else
                set_size(sizes[$urandom_range(0, 5)]);
            no_idle = (ph % 5 == 2);
            if (ph == 3)
                long_hold = 1'b1;
            if ($urandom_range(0, 1) == 0)
                send(OP_CLEAR, {$urandom, $urandom}, 1'b0, 16'd0, 16'd0);
            n = 65;
            repeat (n) rand_word();
        end
        no_idle = 1'b0;
        req.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
